@@ design/dmrh_pkg.sv @@
package dmrh_pkg;
    localparam int MAX_LEN = 4096;
    localparam int AW = $clog2(MAX_LEN + 1);
    localparam int LW = 13;
    localparam int HW = 30;
    localparam int BW = 9;
    localparam logic [HW-1:0] MOD_FIRST = 30'd1000000007;
    localparam logic [HW-1:0] MOD_SECOND = 30'd1000000009;
    localparam logic [1:0] K_CLEAR = 2'd0;
    localparam logic [1:0] K_APPEND = 2'd1;
    localparam logic [1:0] K_QUERY = 2'd2;
    localparam logic [0:0] CFG_BASE_FIRST = 1'b0;
    localparam logic [0:0] CFG_BASE_SECOND = 1'b1;

    typedef struct packed {
        logic [1:0]    kind;
        logic [7:0]    ch;
        logic [LW-1:0] la;
        logic [LW-1:0] ra;
        logic [LW-1:0] lb;
        logic [LW-1:0] rb;
    } t_req;

    // one conditional subtract: reduces a < 2m modulo m
    function automatic logic [HW:0] sub_mod(input logic [HW:0] a, input logic [HW-1:0] m);
        sub_mod = (a >= {1'b0, m}) ? a - {1'b0, m} : a;
    endfunction
endpackage

@@ design/dmrh_front.sv @@
module dmrh_front import dmrh_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_req          i_req,
    input  logic          i_pop,
    output logic          o_empty,
    output logic          o_full,
    output t_req          o_req
);
    // two-entry request queue
    t_req       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_req   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_req;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

@@ design/dmrh_mulmod.sv @@
module dmrh_mulmod import dmrh_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic [HW-1:0] i_a,
    input  logic [HW-1:0] i_b,
    input  logic [HW-1:0] i_add,
    input  logic [HW-1:0] i_m,
    output logic          o_done,
    output logic [HW-1:0] o_p
);
    // shift-add modular product, two bits of b per cycle until all 30 are in, then
    // a last step to fold in the addend: (a*b + add) mod m
    logic [HW-1:0] r_a, r_b, r_m, r_acc, r_add;
    logic [4:0]    r_cnt;
    logic          r_run;
    logic [HW:0]   n_s1, n_s2, n_t1, n_t2;

    always_comb begin
        n_s1 = sub_mod({r_acc, 1'b0}, r_m);
        n_t1 = r_b[HW-1] ? sub_mod(n_s1 + {1'b0, r_a}, r_m) : n_s1;
        n_s2 = sub_mod({n_t1[HW-1:0], 1'b0}, r_m);
        n_t2 = r_b[HW-2] ? sub_mod(n_s2 + {1'b0, r_a}, r_m) : n_s2;
    end

    assign o_p = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0; o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_go) begin
                r_run <= 1'b1; r_cnt <= 5'd0;
            end else if (r_run) begin
                if (r_cnt == 5'd15) begin
                    r_run <= 1'b0; o_done <= 1'b1;
                end
                r_cnt <= r_cnt + 5'd1;
            end
        end
        if (i_go) begin
            r_a <= HW'(sub_mod({1'b0, i_a}, i_m));
            r_b <= i_b; r_m <= i_m;
            r_add <= HW'(sub_mod({1'b0, i_add}, i_m));
            r_acc <= '0;
        end else if (r_run) begin
            if (r_cnt == 5'd15) begin
                r_acc <= HW'(sub_mod({1'b0, r_acc} + {1'b0, r_add}, r_m));
            end else begin
                r_acc <= n_t2[HW-1:0];
                r_b <= {r_b[HW-3:0], 2'b00};
            end
        end
    end
endmodule

@@ design/dmrh_back.sv @@
module dmrh_back import dmrh_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  t_req          i_req,
    output logic          o_pop,
    input  logic [BW-1:0] i_base1,
    input  logic [BW-1:0] i_base2,
    output logic          o_valid,
    output logic [HW-1:0] o_hash_first,
    output logic [HW-1:0] o_hash_second,
    output logic          o_ranges_equal,
    output logic          o_status_ok,
    output logic [LW-1:0] o_cur_length
);
    localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_RDW = 4'd2, S_MUL = 4'd3,
                           S_MW = 4'd4, S_WR = 4'd5, S_Q2 = 4'd6, S_OUT = 4'd7;
    // memories: h1,h2,p1,p2
    logic [HW-1:0] m_h1 [MAX_LEN+1];
    logic [HW-1:0] m_h2 [MAX_LEN+1];
    logic [HW-1:0] m_p1 [MAX_LEN+1];
    logic [HW-1:0] m_p2 [MAX_LEN+1];
    logic [3:0]    r_st;
    t_req          r_req;
    logic [LW-1:0] r_len;
    logic          r_sel;      // 0 range a, 1 range b
    logic [AW-1:0] r_ah, r_ap;
    logic [HW-1:0] r_dh1, r_dh2, r_dp1, r_dp2, r_hr1, r_hr2;
    logic [HW-1:0] r_g1a, r_g2a;
    logic          r_va;
    logic          r_we;
    logic          r_mgo;
    logic [HW-1:0] n_a [4];
    logic [HW-1:0] n_b [4];
    logic [HW-1:0] n_ad [4];
    logic [HW-1:0] n_m [4];
    logic [HW-1:0] w_p [4];
    logic [3:0]    w_d;
    logic [LW-1:0] n_l, n_r;
    logic          n_v;
    logic [HW:0]   n_f1, n_f2;

    assign n_l = r_sel ? r_req.lb : r_req.la;
    assign n_r = r_sel ? r_req.rb : r_req.ra;
    assign n_v = (n_l < n_r) && (n_r <= r_len);
    assign o_pop = (r_st == S_IDLE) && !i_empty;

    always_comb begin
        // append: h*B+c, p*B; query: h[l]*p[r-l] (units 0,1), units 2,3 unused
        n_a[0] = r_dh1; n_b[0] = (r_req.kind == K_APPEND) ? HW'(i_base1) : r_dp1;
        n_a[1] = r_dh2; n_b[1] = (r_req.kind == K_APPEND) ? HW'(i_base2) : r_dp2;
        n_a[2] = r_dp1; n_b[2] = HW'(i_base1);
        n_a[3] = r_dp2; n_b[3] = HW'(i_base2);
        n_ad[0] = (r_req.kind == K_APPEND) ? HW'(r_req.ch) : '0;
        n_ad[1] = n_ad[0]; n_ad[2] = '0; n_ad[3] = '0;
        n_m[0] = MOD_FIRST; n_m[1] = MOD_SECOND; n_m[2] = MOD_FIRST; n_m[3] = MOD_SECOND;
        // (h[r] + m - sub) mod m
        n_f1 = sub_mod({1'b0, r_hr1} + {1'b0, MOD_FIRST} - {1'b0, w_p[0]}, MOD_FIRST);
        n_f2 = sub_mod({1'b0, r_hr2} + {1'b0, MOD_SECOND} - {1'b0, w_p[1]}, MOD_SECOND);
    end

    for (genvar g = 0; g < 4; g++) begin : g_mul
        dmrh_mulmod u_mm (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(r_mgo),
            .i_a(n_a[g]), .i_b(n_b[g]), .i_add(n_ad[g]), .i_m(n_m[g]),
            .o_done(w_d[g]), .o_p(w_p[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            m_h1[r_ah] <= w_p[0]; m_h2[r_ah] <= w_p[1];
            m_p1[r_ah] <= w_p[2]; m_p2[r_ah] <= w_p[3];
        end
        r_dh1 <= (r_ah == '0) ? '0 : m_h1[r_ah];
        r_dh2 <= (r_ah == '0) ? '0 : m_h2[r_ah];
        r_hr1 <= (r_ap == '0) ? '0 : m_h1[r_ap];
        r_hr2 <= (r_ap == '0) ? '0 : m_h2[r_ap];
        r_dp1 <= (r_ap == '0) ? HW'(1) : m_p1[r_ap];
        r_dp2 <= (r_ap == '0) ? HW'(1) : m_p2[r_ap];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_len <= '0; o_valid <= 1'b0; r_we <= 1'b0; r_mgo <= 1'b0;
        end else begin
            o_valid <= 1'b0; r_we <= 1'b0; r_mgo <= 1'b0;
            case (r_st)
                S_IDLE: if (!i_empty) begin
                    r_req <= i_req; r_sel <= 1'b0; r_st <= S_RD;
                end
                S_RD: begin
                    o_hash_first <= '0; o_hash_second <= '0;
                    o_ranges_equal <= 1'b0; o_status_ok <= 1'b1;
                    if (r_req.kind == K_CLEAR) begin
                        r_len <= '0; o_cur_length <= '0; r_st <= S_OUT;
                    end else if (r_req.kind == K_APPEND) begin
                        if (r_len < LW'(MAX_LEN)) begin
                            r_ah <= AW'(r_len); r_ap <= AW'(r_len); r_st <= S_RDW;
                        end else begin
                            o_status_ok <= 1'b0; o_cur_length <= r_len; r_st <= S_OUT;
                        end
                    end else if (r_req.kind == K_QUERY) begin
                        r_ah <= AW'(n_l); r_ap <= AW'(n_r - n_l); r_st <= S_RDW;
                    end else begin
                        o_cur_length <= r_len; r_st <= S_OUT;
                    end
                end
                S_RDW: begin
                    // ap is set to r here for the h[r] read after the mul launch
                    r_mgo <= 1'b1; r_st <= S_MUL;
                    if (r_req.kind == K_QUERY) r_ap <= AW'(n_r);
                end
                S_MUL: r_st <= S_MW;
                S_MW: if (w_d[0]) r_st <= (r_req.kind == K_APPEND) ? S_WR : S_Q2;
                S_WR: begin
                    r_we <= 1'b1; r_ah <= AW'(r_len + LW'(1));
                    r_len <= r_len + LW'(1); o_cur_length <= r_len + LW'(1);
                    r_st <= S_OUT;
                end
                S_Q2: begin
                    if (!r_sel) begin
                        r_va <= n_v;
                        r_g1a <= n_v ? n_f1[HW-1:0] : '0;
                        r_g2a <= n_v ? n_f2[HW-1:0] : '0;
                        r_sel <= 1'b1; r_st <= S_RD;
                    end else begin
                        o_hash_first <= r_g1a; o_hash_second <= r_g2a;
                        o_status_ok <= r_va;
                        o_ranges_equal <= (r_g1a == (n_v ? n_f1[HW-1:0] : '0))
                                       && (r_g2a == (n_v ? n_f2[HW-1:0] : '0));
                        o_cur_length <= r_len; r_st <= S_OUT;
                    end
                end
                S_OUT: begin
                    o_valid <= 1'b1; r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

@@ design/double_mod_rolling_hash_store_top.sv @@
// Rolling hash store: clear, append and two-range query requests. A request
// is taken when start is high and busy low; one result per request shows
// on the o_ ports for a single cycle with o_done and cannot be stalled.
// The back end takes a request from the queue only when idle. A clear or
// kind 3 goes straight to output; an append, unless full, reads the tables,
// multiplies and writes back; a query reads and multiplies for each range.
// Queued requests wait; multipliers do two product bits a step, then addend.
module double_mod_rolling_hash_store_top import dmrh_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  logic          i_cfg_we,
    input  logic [0:0]    i_cfg_index,
    input  logic [BW-1:0] i_cfg_data,
    input  logic [1:0]    i_kind,
    input  logic [7:0]    i_char_in,
    input  logic [LW-1:0] i_start_a,
    input  logic [LW-1:0] i_end_a,
    input  logic [LW-1:0] i_start_b,
    input  logic [LW-1:0] i_end_b,
    output logic          o_done,
    output logic [HW-1:0] o_hash_first,
    output logic [HW-1:0] o_hash_second,
    output logic          o_ranges_equal,
    output logic          o_status_ok,
    output logic [LW-1:0] o_cur_length
);
    logic [BW-1:0] r_base1, r_base2;
    t_req w_in, w_q;
    logic w_empty, w_full, w_pop;

    assign w_in = '{kind: i_kind, ch: i_char_in, la: i_start_a, ra: i_end_a,
                    lb: i_start_b, rb: i_end_b};
    assign busy = w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base1 <= 9'd257; r_base2 <= 9'd307;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_BASE_FIRST) r_base1 <= i_cfg_data;
            if (i_cfg_index == CFG_BASE_SECOND) r_base2 <= i_cfg_data;
        end
    end

    dmrh_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(start && !busy), .i_req(w_in),
        .i_pop(w_pop), .o_empty(w_empty), .o_full(w_full), .o_req(w_q)
    );

    dmrh_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(w_empty), .i_req(w_q),
        .o_pop(w_pop), .i_base1(r_base1), .i_base2(r_base2), .o_valid(o_done),
        .o_hash_first(o_hash_first), .o_hash_second(o_hash_second),
        .o_ranges_equal(o_ranges_equal), .o_status_ok(o_status_ok),
        .o_cur_length(o_cur_length)
    );
endmodule

@@ design/dmrh_checker.sv @@
module dmrh_assertions import dmrh_pkg::*; (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_done,
    input logic [HW-1:0] o_hash_first,
    input logic          o_status_ok,
    input logic [LW-1:0] o_cur_length
);
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_cur_length <= LW'(MAX_LEN)) else $error("length overflow");
    a_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_hash_first < MOD_FIRST) else $error("hash out of range");
    a_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_status_ok) |-> o_hash_first == '0) else $error("hash on error");
    a_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("back to back done");
endmodule

bind double_mod_rolling_hash_store_top dmrh_assertions u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_done(o_done),
    .o_hash_first(o_hash_first), .o_status_ok(o_status_ok), .o_cur_length(o_cur_length)
);
